>>> hw/rtl/cfv_pkg.sv
// Shared types and constants for the candidate frame vote unit.
// No dependencies.
package cfv_pkg;

    localparam int unsigned MSG_W   = 56;
    localparam int unsigned LEVEL_W = 32;
    localparam int unsigned DIVR_W  = 8;

    localparam logic [5:0] TYPE_MODE_A = 6'd32;
    localparam logic [5:0] TYPE_DF11   = 6'd11;
    localparam logic [6:0] LEN_SHORT   = 7'd56;
    localparam logic [6:0] LEN_MODE_A  = 7'd16;
    localparam logic [3:0] MAX_BYTES   = 4'd14;

    typedef struct packed {
        logic [55:0] msg_upper;
        logic [55:0] msg_lower;
        logic [6:0]  bit_count;
        logic [5:0]  frame_type;
        logic [27:0] signal_level;
        logic [63:0] time_stamp;
        logic [7:0]  crc_residue;
        logic        last_candidate;
    } cand_t;

    typedef struct packed {
        logic [55:0] best_upper;
        logic [55:0] best_lower;
        logic [6:0]  best_bits;
        logic [5:0]  best_type;
        logic [31:0] best_level;
        logic [63:0] best_time;
        logic [7:0]  best_crc;
        logic [7:0]  vote_count;
        logic [4:0]  distinct_count;
    } result_t;

    typedef struct packed {
        logic [55:0] upper;
        logic [55:0] lower;
        logic [6:0]  bits;
        logic [5:0]  ftype;
        logic [31:0] level;
        logic [63:0] stamp;
        logic [7:0]  crc;
        logic [7:0]  votes;
    } entry_t;

endpackage

>>> hw/rtl/cfv_divider.sv
// Restoring divider, one quotient bit per cycle, for level normalization.
// Depends on cfv_pkg.
module cfv_divider (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [cfv_pkg::LEVEL_W-1:0] dividend,
    input  logic [cfv_pkg::DIVR_W-1:0]  divisor,
    output logic                        done,
    output logic [cfv_pkg::LEVEL_W-1:0] quotient
);
    import cfv_pkg::*;

    logic                 run_reg, run_next;
    logic                 done_reg, done_next;
    logic [5:0]           cnt_reg, cnt_next;
    logic [LEVEL_W-1:0]   q_reg, q_next;
    logic [DIVR_W-1:0]    rem_reg, rem_next;
    logic [DIVR_W-1:0]    div_reg, div_next;
    logic [DIVR_W:0]      trial;

    // one shift/subtract step per cycle
    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        trial     = {rem_reg, q_reg[LEVEL_W-1]};
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = 6'(LEVEL_W - 1);
            q_next   = dividend;
            rem_next = '0;
            div_next = divisor;
        end
        else if (run_reg)
        begin
            if (trial >= {1'b0, div_reg})
            begin
                rem_next = DIVR_W'(trial - {1'b0, div_reg});
                q_next   = {q_reg[LEVEL_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DIVR_W-1:0];
                q_next   = {q_reg[LEVEL_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd0)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

    a_done_after_run: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !run_reg) else $error("divider done while running");
    a_start_runs: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> run_reg) else $error("divider did not start");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg) else $error("divider done held");

endmodule

>>> hw/rtl/candidate_frame_vote_unit.sv
// Top level: candidate frame vote unit, entry table memory and sequencer.
// Depends on cfv_pkg and cfv_divider.
//
//  channel   direction  handshake            payload
//  item      in         start && !busy       cand   (cand_t)
//  result    out        done, one cycle      result (result_t)
//
// An item stays busy through the level division, then the match walk, which reads
// and compares each stored entry in turn until a hit or the end of the table, and
// on the last candidate the winner walk over every entry; the registered read of
// the entry memory sets the walk cost. The next item is taken while busy is low.
// Reset empties the table at once (no clearing pass). The result is shown
// for one cycle under done and cannot be held off by the receiver.
module candidate_frame_vote_unit #(
    parameter int unsigned MAX_DISTINCT = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  cfv_pkg::cand_t   cand,
    output logic             busy,
    output logic             done,
    output cfv_pkg::result_t result
);
    import cfv_pkg::*;

    localparam int unsigned AW = (MAX_DISTINCT > 1) ? $clog2(MAX_DISTINCT) : 1;
    localparam int unsigned CW = $clog2(MAX_DISTINCT + 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_RD   = 3'd2;
    localparam logic [2:0] ST_CMP  = 3'd3;
    localparam logic [2:0] ST_END  = 3'd4;
    localparam logic [2:0] ST_BRD  = 3'd5;
    localparam logic [2:0] ST_BCMP = 3'd6;

    logic [2:0]          state_reg, state_next;
    logic [CW-1:0]       used_reg, used_next;
    logic [CW-1:0]       idx_reg, idx_next;
    cand_t               cand_reg;
    logic [6:0]          bits_reg;
    logic [LEVEL_W-1:0]  level_reg, level_next;
    entry_t              best_reg, best_next;
    logic                done_reg, done_next;
    result_t             res_reg, res_next;

    entry_t              mem [MAX_DISTINCT];
    entry_t              rd_data;
    logic                rd_en;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    entry_t              wr_data;

    logic                div_start;
    logic                div_done;
    logic [LEVEL_W-1:0]  div_q;
    logic [DIVR_W-1:0]   divisor;

    logic [111:0]        cand_msg;
    logic [111:0]        ent_msg;
    logic [13:0]         byte_eq;
    logic [13:0]         byte_use;
    logic [3:0]          nbytes;
    logic                exact_hit;
    logic                df11_hit;

    // level normalization divisor
    assign divisor = (start && !busy && cand.frame_type == TYPE_MODE_A)
                     ? DIVR_W'({1'b0, cand.bit_count} + 8'd2)
                     : DIVR_W'({1'b0, cand.bit_count} + 8'd4);
    assign div_start = start && !busy;

    cfv_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({cand.signal_level, 4'b0000}),
        .divisor  (divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    // entry table: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[idx_reg[AW-1:0]];
        end
    end

    // byte compare of candidate against the entry just read
    always_comb
    begin
        cand_msg = {cand_reg.msg_upper, cand_reg.msg_lower};
        ent_msg  = {rd_data.upper, rd_data.lower};
        nbytes = (bits_reg[6:3] > MAX_BYTES) ? MAX_BYTES : bits_reg[6:3];
        for (int k = 0; k < 14; k++)
        begin
            byte_eq[k]  = (cand_msg[8*(13-k) +: 8] == ent_msg[8*(13-k) +: 8]);
            byte_use[k] = (4'(k) < nbytes);
        end
        exact_hit = (rd_data.bits == bits_reg) && (&(byte_eq | ~byte_use));
        df11_hit  = (rd_data.bits == bits_reg) && (bits_reg == LEN_SHORT) &&
                    (rd_data.ftype == TYPE_DF11) && (&byte_eq[5:0]);
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        used_next  = used_reg;
        idx_next   = idx_reg;
        level_next = level_reg;
        best_next  = best_reg;
        done_next  = 1'b0;
        res_next   = res_reg;
        rd_en      = 1'b0;
        wr_en      = 1'b0;
        wr_addr    = idx_reg[AW-1:0];
        wr_data    = rd_data;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    level_next = div_q;
                    idx_next   = '0;
                    state_next = ST_RD;
                end
            end
            ST_RD:
            begin
                if (idx_reg == used_reg)
                begin
                    // no match: append when room is left
                    if (used_reg < CW'(MAX_DISTINCT))
                    begin
                        wr_en         = 1'b1;
                        wr_addr       = used_reg[AW-1:0];
                        wr_data.upper = cand_reg.msg_upper;
                        wr_data.lower = cand_reg.msg_lower;
                        wr_data.bits  = bits_reg;
                        wr_data.ftype = cand_reg.frame_type;
                        wr_data.level = level_reg;
                        wr_data.stamp = cand_reg.time_stamp;
                        wr_data.crc   = cand_reg.crc_residue;
                        wr_data.votes = 8'd1;
                        used_next     = used_reg + CW'(1);
                    end
                    state_next = ST_END;
                end
                else
                begin
                    rd_en      = 1'b1;
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                if (exact_hit || df11_hit)
                begin
                    wr_en = 1'b1;
                    if (level_reg > rd_data.level)
                    begin
                        wr_data.level = level_reg;
                        wr_data.stamp = cand_reg.time_stamp;
                    end
                    if (rd_data.votes != 8'hFF)
                    begin
                        wr_data.votes = rd_data.votes + 8'd1;
                    end
                    if (!exact_hit)
                    begin
                        wr_data.upper = rd_data.upper ^ {48'd0, rd_data.crc};
                        wr_data.crc   = '0;
                    end
                    state_next = ST_END;
                end
                else
                begin
                    idx_next   = idx_reg + CW'(1);
                    state_next = ST_RD;
                end
            end
            ST_END:
            begin
                idx_next   = '0;
                state_next = cand_reg.last_candidate ? ST_BRD : ST_IDLE;
            end
            ST_BRD:
            begin
                if (idx_reg == used_reg)
                begin
                    res_next.best_upper     = best_reg.upper;
                    res_next.best_lower     = best_reg.lower;
                    res_next.best_bits      = best_reg.bits;
                    res_next.best_type      = best_reg.ftype;
                    res_next.best_level     = best_reg.level;
                    res_next.best_time      = best_reg.stamp;
                    res_next.best_crc       = best_reg.crc;
                    res_next.vote_count     = best_reg.votes;
                    res_next.distinct_count = 5'(used_reg);
                    done_next  = 1'b1;
                    used_next  = '0;
                    idx_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    state_next = ST_BCMP;
                end
            end
            ST_BCMP:
            begin
                if (idx_reg == '0 || rd_data.votes > best_reg.votes ||
                    (rd_data.votes == best_reg.votes && rd_data.level > best_reg.level))
                begin
                    best_next = rd_data;
                end
                idx_next   = idx_reg + CW'(1);
                state_next = ST_BRD;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            used_reg  <= '0;
            idx_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            used_reg  <= used_next;
            idx_reg   <= idx_next;
            done_reg  <= done_next;
        end
    end

    // item capture and working payload
    always_ff @(posedge clk)
    begin
        if (div_start)
        begin
            cand_reg <= cand;
            bits_reg <= (cand.frame_type == TYPE_MODE_A) ? LEN_MODE_A : cand.bit_count;
        end
        level_reg <= level_next;
        best_reg  <= best_next;
        res_reg   <= res_next;
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = res_reg;

    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= CW'(MAX_DISTINCT)) else $error("table overfilled");
    a_done_clears: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (used_reg == '0 && !busy)) else $error("table not emptied");
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy) else $error("item accepted without work");
    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= used_reg) else $error("walk beyond table");

endmodule
